// ----- rtl/bfl_pkg.sv -----
// shared types, constants and helpers for the buddy free list block
// no dependencies
`timescale 1ns / 1ps
package bfl_pkg;

  localparam int ENTRIES    = 256;
  localparam int FRAME_BITS = 20;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int ORDER_W    = 4;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    OUT_GOT    = 3'd0,
    OUT_EMPTY  = 3'd1,
    OUT_STORED = 3'd2,
    OUT_MERGED = 3'd3,
    OUT_FULL   = 3'd4
  } outcome_t;

  typedef enum logic {
    REG_BLOCK_ORDER   = 1'b0,
    REG_MERGE_DISABLE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t    op;
    frame_t frame;
  } req_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic               merge_disable;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GET_W, S_SRCH, S_SRCH_W, S_LO, S_LO_W, S_HI, S_HI_W,
    S_DECIDE, S_RM, S_RM_W, S_INS, S_INS_W, S_DONE
  } back_state_t;

  // logical position to physical slot of the circular table
  function automatic idx_t phys(input idx_t base, input idx_t pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(ENTRIES)) sum = sum - (IDX_W+1)'(ENTRIES);
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/buddy_free_list_coalescer.sv -----
// top level of the buddy free list: config registers, front queue, back end
// depends on bfl_pkg, bfl_front, bfl_back
`timescale 1ns / 1ps
// usage:
//   in_* carries requests: in_tuser is the action (0 get lowest, 1 put),
//   in_tdata holds the frame number. out_* returns one item per request:
//   out_tuser is the outcome code, out_tdata holds result frame and count.
//   cfg_* writes block_order (index 0) or merge_disable (index 1); write only
//   while the block is idle, which it does not enforce; cfg_ready is always high.
// operation, with the back end idle: a get reads the head entry of the table, an
//   empty get answers without a read. a put runs a binary search over the stored
//   entries, one read of the table memory a step (one read port), about
//   log2(n) + 1 steps for n stored, then reads the lower and upper neighbors
//   where they exist, then shifts entries one at a time to close or open
//   a slot. one item is in the back end at a time.
// reset: the table is empty, order 0, merging enabled. table contents need
//   no clearing since only stored entries are read.
// stalls: a two-item queue accepts requests until full while the back end works
//   or the output register waits; the back end holds its result until the
//   output register is free.
module buddy_free_list_coalescer import bfl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] frame_number, [23:20] zero
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [19:0] result_frame, [28:20] entry_count, [31:29] zero
  output logic [2:0]  out_tuser,  // [2:0] outcome
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_valid, q_pop;
  req_t     q_req;
  frame_t   res_frame;
  outcome_t res_outc;
  cnt_t     res_cnt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BLOCK_ORDER:   cfg_nxt.order = cfg_data;
        REG_MERGE_DISABLE: cfg_nxt.merge_disable = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else cfg_r <= cfg_nxt;
  end

  bfl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_frame (in_tdata[FRAME_BITS-1:0]),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  bfl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_frame  (res_frame),
    .out_outcome(res_outc),
    .out_count  (res_cnt)
  );

  assign out_tdata = {3'b000, res_cnt, res_frame};
  assign out_tuser = res_outc;

endmodule

// ----- rtl/bfl_front.sv -----
// front end: accepts items, tags the operation and queues them
// depends on bfl_pkg
`timescale 1ns / 1ps
module bfl_front import bfl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_action,
  input  frame_t in_frame,
  output logic   q_valid,
  output req_t   q_req,
  input  logic   q_pop
);

  req_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_req    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].op    <= in_action ? OP_PUT : OP_GET;
      q_r[wr_ptr_r].frame <= in_frame;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue fill out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> fill_r != 2'd0)
    else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> fill_r == $past(fill_r) + 2'd1)
    else $error("queue fill not tracking push");

endmodule

// ----- rtl/bfl_back.sv -----
// back end: sorted free table in a circular memory, search, merge, shift
// depends on bfl_pkg
`timescale 1ns / 1ps
module bfl_back import bfl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  req_t     q_req,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output frame_t   out_frame,
  output outcome_t out_outcome,
  output cnt_t     out_count
);

  frame_t      mem_r [ENTRIES];
  frame_t      rd_data_r;
  idx_t        rd_addr, wr_addr;
  frame_t      wr_data;
  logic        we;

  back_state_t st_r, st_nxt;
  frame_t      fr_r, fr_nxt;
  cnt_t        lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt, above_r, above_nxt;
  cnt_t        count_r, count_nxt;
  idx_t        base_r, base_nxt;
  frame_t      lov_r, lov_nxt, hiv_r, hiv_nxt;
  frame_t      res_r, res_nxt;
  outcome_t    outc_r, outc_nxt;
  logic        out_valid_r, out_valid_nxt;
  frame_t      out_frame_r, out_frame_nxt;
  outcome_t    out_outc_r, out_outc_nxt;
  cnt_t        out_cnt_r, out_cnt_nxt;

  logic [CNT_W:0] mid_sum;
  idx_t        mid;
  frame_t      span;
  logic        merge_lo, merge_hi, out_free;
  cnt_t        above_m1, idx_p1, idx_m1;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[IDX_W:1];
  assign span     = frame_t'(1) << cfg.order;
  assign above_m1 = above_r - cnt_t'(1);
  assign idx_p1   = idx_r + cnt_t'(1);
  assign idx_m1   = idx_r - cnt_t'(1);
  assign out_free = !out_valid_r || out_ready;
  assign merge_lo = !cfg.merge_disable && (above_r != '0) &&
                    ((fr_r - lov_r) == span) && ((lov_r & span) == '0);
  assign merge_hi = !cfg.merge_disable && (above_r < count_r) && (hiv_r > fr_r) &&
                    ((hiv_r - fr_r) == span) && ((fr_r & span) == '0);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:   if (q_valid) begin
        if (q_req.op == OP_PUT) st_nxt = S_SRCH;
        else if (count_r == '0) st_nxt = S_DONE;
        else st_nxt = S_GET_W;
      end
      S_GET_W:  st_nxt = S_DONE;
      S_SRCH:   st_nxt = (lo_r == hi_r) ? S_LO : S_SRCH_W;
      S_SRCH_W: st_nxt = S_SRCH;
      S_LO:     st_nxt = (above_r != '0) ? S_LO_W : S_HI;
      S_LO_W:   st_nxt = S_HI;
      S_HI:     st_nxt = (above_r < count_r) ? S_HI_W : S_DECIDE;
      S_HI_W:   st_nxt = S_DECIDE;
      S_DECIDE: begin
        if (merge_lo || merge_hi) st_nxt = S_RM;
        else if (count_r == cnt_t'(ENTRIES)) st_nxt = S_DONE;
        else st_nxt = S_INS;
      end
      S_RM:     st_nxt = (idx_p1 >= count_r) ? S_DONE : S_RM_W;
      S_RM_W:   st_nxt = S_RM;
      S_INS:    st_nxt = (idx_r == above_r) ? S_DONE : S_INS_W;
      S_INS_W:  st_nxt = S_INS;
      S_DONE:   if (out_free) st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    fr_nxt = fr_r; lo_nxt = lo_r; hi_nxt = hi_r; idx_nxt = idx_r;
    above_nxt = above_r; count_nxt = count_r; base_nxt = base_r;
    lov_nxt = lov_r; hiv_nxt = hiv_r; res_nxt = res_r; outc_nxt = outc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_frame_nxt = out_frame_r; out_outc_nxt = out_outc_r; out_cnt_nxt = out_cnt_r;
    rd_addr = base_r; wr_addr = base_r; wr_data = fr_r; we = 1'b0;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        q_pop   = 1'b1;
        fr_nxt  = q_req.frame;
        res_nxt = '0;
        lo_nxt  = '0;
        hi_nxt  = count_r;
        outc_nxt = OUT_EMPTY;
      end
      S_GET_W: begin
        res_nxt   = rd_data_r;
        outc_nxt  = OUT_GOT;
        base_nxt  = phys(base_r, idx_t'(1));
        count_nxt = count_r - cnt_t'(1);
      end
      S_SRCH: begin
        if (lo_r == hi_r) above_nxt = lo_r;
        rd_addr = phys(base_r, mid);
      end
      S_SRCH_W: begin
        if (rd_data_r < fr_r) lo_nxt = cnt_t'(mid) + cnt_t'(1);
        else hi_nxt = cnt_t'(mid);
      end
      S_LO:   rd_addr = phys(base_r, above_m1[IDX_W-1:0]);
      S_LO_W: lov_nxt = rd_data_r;
      S_HI:   rd_addr = phys(base_r, above_r[IDX_W-1:0]);
      S_HI_W: hiv_nxt = rd_data_r;
      S_DECIDE: begin
        if (merge_lo) begin
          res_nxt = lov_r; outc_nxt = OUT_MERGED; idx_nxt = above_m1;
        end else if (merge_hi) begin
          res_nxt = fr_r; outc_nxt = OUT_MERGED; idx_nxt = above_r;
        end else if (count_r == cnt_t'(ENTRIES)) begin
          outc_nxt = OUT_FULL;
        end else begin
          outc_nxt = OUT_STORED; idx_nxt = count_r;
        end
      end
      // close the gap: pull entries above idx down by one
      S_RM: begin
        rd_addr = phys(base_r, idx_p1[IDX_W-1:0]);
        if (idx_p1 >= count_r) count_nxt = count_r - cnt_t'(1);
      end
      S_RM_W: begin
        we = 1'b1;
        wr_addr = phys(base_r, idx_r[IDX_W-1:0]);
        wr_data = rd_data_r;
        idx_nxt = idx_p1;
      end
      // open a gap at above, walking down from the top
      S_INS: begin
        rd_addr = phys(base_r, idx_m1[IDX_W-1:0]);
        if (idx_r == above_r) begin
          we = 1'b1;
          wr_addr = phys(base_r, above_r[IDX_W-1:0]);
          wr_data = fr_r;
          count_nxt = count_r + cnt_t'(1);
        end
      end
      S_INS_W: begin
        we = 1'b1;
        wr_addr = phys(base_r, idx_r[IDX_W-1:0]);
        wr_data = rd_data_r;
        idx_nxt = idx_m1;
      end
      S_DONE: if (out_free) begin
        out_valid_nxt = 1'b1;
        out_frame_nxt = res_r;
        out_outc_nxt  = outc_r;
        out_cnt_nxt   = count_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_r <= fr_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt;
    above_r <= above_nxt; lov_r <= lov_nxt; hiv_r <= hiv_nxt;
    res_r <= res_nxt; outc_r <= outc_nxt;
    out_frame_r <= out_frame_nxt; out_outc_r <= out_outc_nxt; out_cnt_r <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  assign out_valid   = out_valid_r;
  assign out_frame   = out_frame_r;
  assign out_outcome = out_outc_r;
  assign out_count   = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(ENTRIES))
    else $error("entry count beyond table size");
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SRCH) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of range");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && outc_r == OUT_EMPTY) |-> count_r == '0)
    else $error("empty outcome with entries stored");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE)
    else $error("queue popped while busy");

endmodule
